// File: rtl/i2cbm_pkg.sv
// Shared types and constants of the bit-level I2C master sequencer.
package i2cbm_pkg;

    // Byte framing on the bus
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_COUNT_W   = $clog2(BITS_PER_BYTE + 1);

    // Wait counter width default
    localparam int WAIT_WIDTH_DEF = 16;

    // Configuration register widths and reset values
    localparam int DELAY_W      = 16;
    localparam int TIMEOUT_W    = 8;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;
    localparam logic [DELAY_W-1:0]   DELAY_RESET   = 16'd100;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd200;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_TICKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT = 1'b1;

    // Command codes
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // Sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE, PH_FIN,
        PH_S_SDA1, PH_S_SCL1, PH_S_SDA0, PH_S_SCL0,
        PH_P_SDA0, PH_P_SCL1, PH_P_SDA1,
        PH_W_SCL0, PH_W_BIT, PH_W_SCLH, PH_W_SCLL,
        PH_A_SDA1, PH_A_SCL1, PH_A_POLL, PH_A_SCL0,
        PH_N_SCL1, PH_N_SDA1,
        PH_R_SCL0, PH_R_SCLH, PH_R_SCLL,
        PH_K_SDA1, PH_K_SCL1, PH_K_SCL0
    } phase_t;

endpackage

// File: rtl/i2c_bit_level_master_unit.sv
// Bit-level I2C master sequencer: one input item per clock tick of the bus sequencer.
// Latency: the result item for an accepted tick is valid on the next cycle.
// Throughput: one item per cycle; the state registers and the result register are
// updated together on accept, so a new item is taken whenever the result is taken.
// Reset: idle, SCL and SDA released high, counters, nack and read byte cleared,
// delay_ticks = 100, ack_timeout = 200.
module i2c_bit_level_master_unit #(
    parameter int WAIT_WIDTH = i2cbm_pkg::WAIT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input item channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [i2cbm_pkg::OP_W-1:0]           op,
    input  logic [i2cbm_pkg::BITS_PER_BYTE-1:0]  wr_byte,
    input  logic                                 sda_in,
    // result item channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 scl_out,
    output logic                                 sda_out,
    output logic                                 busy_res,
    output logic                                 done_res,
    output logic [i2cbm_pkg::BITS_PER_BYTE-1:0]  rd_byte,
    output logic                                 nack,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [i2cbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NB  = i2cbm_pkg::BITS_PER_BYTE;
    localparam int BCW = i2cbm_pkg::BIT_COUNT_W;
    localparam int TW  = i2cbm_pkg::TIMEOUT_W;

    // Configuration registers
    logic [i2cbm_pkg::DELAY_W-1:0] delay_reg;
    logic [TW-1:0]                 timeout_reg;

    // Sequencer state
    i2cbm_pkg::phase_t phase_reg, phase_next;
    logic [WAIT_WIDTH-1:0] wait_reg, wait_next;
    logic [BCW-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [NB-1:0]         shift_reg, shift_next;
    logic [TW-1:0]         poll_reg, poll_next;
    logic                  nack_reg, nack_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic [NB-1:0]         rd_hold_reg, rd_hold_next;
    logic                  done_reg, done_next;
    logic                  out_valid_reg;

    // Decode
    logic              accept;
    logic              is_idle;
    logic              cmd_valid;
    logic              run;
    i2cbm_pkg::phase_t act_phase;
    i2cbm_pkg::phase_t cmd_phase;
    logic [BCW-1:0]    bit_inc;
    logic              byte_end;
    logic [NB-1:0]     rd_shift;
    logic              poll_timeout;
    logic [WAIT_WIDTH-1:0] wait_load;

    // Take a new tick whenever the result slot is empty or being drained.
    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    assign is_idle   = (phase_reg == i2cbm_pkg::PH_IDLE);
    assign cmd_valid = (op == i2cbm_pkg::OP_START) || (op == i2cbm_pkg::OP_STOP) ||
                       (op == i2cbm_pkg::OP_WRITE) || (op == i2cbm_pkg::OP_READ);

    // A command acts on the tick it arrives; otherwise act once the wait has run out.
    assign run = is_idle ? cmd_valid : (wait_reg == '0);

    always_comb
    begin
        unique case (op)
            i2cbm_pkg::OP_START: cmd_phase = i2cbm_pkg::PH_S_SDA1;
            i2cbm_pkg::OP_STOP:  cmd_phase = i2cbm_pkg::PH_P_SDA0;
            i2cbm_pkg::OP_WRITE: cmd_phase = i2cbm_pkg::PH_W_SCL0;
            i2cbm_pkg::OP_READ:  cmd_phase = i2cbm_pkg::PH_R_SCL0;
            default:             cmd_phase = i2cbm_pkg::PH_IDLE;
        endcase
    end

    assign act_phase = is_idle ? cmd_phase : phase_reg;

    // A new command restarts the bit counter, so count from zero in that case.
    assign bit_inc      = (is_idle ? '0 : bit_cnt_reg) + BCW'(1);
    assign byte_end     = (bit_inc >= BCW'(NB));
    assign rd_shift     = {shift_reg[NB-2:0], sda_in};
    assign poll_timeout = (poll_reg >= timeout_reg);
    // Truncate or extend the configured delay to the counter width.
    assign wait_load    = WAIT_WIDTH'(delay_reg);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (run)
        begin
            unique case (act_phase)
                i2cbm_pkg::PH_IDLE:   phase_next = i2cbm_pkg::PH_IDLE;
                i2cbm_pkg::PH_FIN:    phase_next = i2cbm_pkg::PH_IDLE;
                i2cbm_pkg::PH_S_SDA1: phase_next = i2cbm_pkg::PH_S_SCL1;
                i2cbm_pkg::PH_S_SCL1: phase_next = i2cbm_pkg::PH_S_SDA0;
                i2cbm_pkg::PH_S_SDA0: phase_next = i2cbm_pkg::PH_S_SCL0;
                i2cbm_pkg::PH_S_SCL0: phase_next = i2cbm_pkg::PH_FIN;
                i2cbm_pkg::PH_P_SDA0: phase_next = i2cbm_pkg::PH_P_SCL1;
                i2cbm_pkg::PH_P_SCL1: phase_next = i2cbm_pkg::PH_P_SDA1;
                i2cbm_pkg::PH_P_SDA1: phase_next = i2cbm_pkg::PH_FIN;
                i2cbm_pkg::PH_W_SCL0: phase_next = i2cbm_pkg::PH_W_BIT;
                i2cbm_pkg::PH_W_BIT:  phase_next = i2cbm_pkg::PH_W_SCLH;
                i2cbm_pkg::PH_W_SCLH: phase_next = i2cbm_pkg::PH_W_SCLL;
                i2cbm_pkg::PH_W_SCLL:
                    phase_next = byte_end ? i2cbm_pkg::PH_A_SDA1 : i2cbm_pkg::PH_W_BIT;
                i2cbm_pkg::PH_A_SDA1: phase_next = i2cbm_pkg::PH_A_SCL1;
                i2cbm_pkg::PH_A_SCL1: phase_next = i2cbm_pkg::PH_A_POLL;
                i2cbm_pkg::PH_A_POLL:
                begin
                    if (!sda_in)
                        phase_next = i2cbm_pkg::PH_FIN;
                    else if (poll_timeout)
                        phase_next = i2cbm_pkg::PH_N_SCL1;
                    else
                        phase_next = i2cbm_pkg::PH_A_POLL;
                end
                i2cbm_pkg::PH_N_SCL1: phase_next = i2cbm_pkg::PH_N_SDA1;
                i2cbm_pkg::PH_N_SDA1: phase_next = i2cbm_pkg::PH_A_SCL0;
                i2cbm_pkg::PH_A_SCL0: phase_next = i2cbm_pkg::PH_FIN;
                i2cbm_pkg::PH_R_SCL0: phase_next = i2cbm_pkg::PH_R_SCLH;
                i2cbm_pkg::PH_R_SCLH: phase_next = i2cbm_pkg::PH_R_SCLL;
                i2cbm_pkg::PH_R_SCLL:
                    phase_next = byte_end ? i2cbm_pkg::PH_K_SDA1 : i2cbm_pkg::PH_R_SCLH;
                i2cbm_pkg::PH_K_SDA1: phase_next = i2cbm_pkg::PH_K_SCL1;
                i2cbm_pkg::PH_K_SCL1: phase_next = i2cbm_pkg::PH_K_SCL0;
                i2cbm_pkg::PH_K_SCL0: phase_next = i2cbm_pkg::PH_FIN;
                default:              phase_next = i2cbm_pkg::PH_IDLE;
            endcase
        end
    end

    // Pin levels, wait counter and datapath registers
    always_comb
    begin
        wait_next    = wait_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        poll_next    = poll_reg;
        nack_next    = nack_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        rd_hold_next = rd_hold_reg;
        done_next    = 1'b0;

        // Count down the wait between pin changes.
        if (!is_idle && !run)
            wait_next = wait_reg - WAIT_WIDTH'(1);

        // Load a new command.
        if (is_idle && cmd_valid)
        begin
            bit_cnt_next = '0;
            poll_next    = '0;
            wait_next    = '0;
            if (op == i2cbm_pkg::OP_WRITE)
            begin
                shift_next = wr_byte;
                nack_next  = 1'b0;
            end
            else if (op == i2cbm_pkg::OP_READ)
                shift_next = '0;
        end

        if (run)
        begin
            unique case (act_phase)
                i2cbm_pkg::PH_FIN:
                    done_next = 1'b1;
                i2cbm_pkg::PH_S_SDA1, i2cbm_pkg::PH_P_SDA1, i2cbm_pkg::PH_A_SDA1,
                i2cbm_pkg::PH_N_SDA1, i2cbm_pkg::PH_K_SDA1:
                begin
                    sda_next  = 1'b1;
                    wait_next = wait_load;
                end
                i2cbm_pkg::PH_S_SDA0, i2cbm_pkg::PH_P_SDA0:
                begin
                    sda_next  = 1'b0;
                    wait_next = wait_load;
                end
                i2cbm_pkg::PH_S_SCL1, i2cbm_pkg::PH_P_SCL1, i2cbm_pkg::PH_W_SCLH,
                i2cbm_pkg::PH_N_SCL1, i2cbm_pkg::PH_R_SCLH, i2cbm_pkg::PH_K_SCL1:
                begin
                    scl_next  = 1'b1;
                    wait_next = wait_load;
                end
                i2cbm_pkg::PH_A_SCL1:
                begin
                    scl_next  = 1'b1;
                    poll_next = '0;
                    wait_next = wait_load;
                end
                i2cbm_pkg::PH_S_SCL0, i2cbm_pkg::PH_W_SCL0, i2cbm_pkg::PH_A_SCL0,
                i2cbm_pkg::PH_R_SCL0, i2cbm_pkg::PH_K_SCL0:
                begin
                    scl_next  = 1'b0;
                    wait_next = wait_load;
                end
                i2cbm_pkg::PH_W_BIT:
                begin
                    // Shift out MSB first.
                    sda_next   = shift_reg[NB-1];
                    shift_next = {shift_reg[NB-2:0], 1'b0};
                    wait_next  = wait_load;
                end
                i2cbm_pkg::PH_W_SCLL:
                begin
                    bit_cnt_next = bit_inc;
                    scl_next     = 1'b0;
                    wait_next    = wait_load;
                end
                i2cbm_pkg::PH_A_POLL:
                begin
                    if (!sda_in)
                    begin
                        // Acknowledged: drop SCL and finish.
                        scl_next  = 1'b0;
                        wait_next = wait_load;
                    end
                    else if (poll_timeout)
                    begin
                        // No acknowledge: flag it and run a stop.
                        nack_next = 1'b1;
                        sda_next  = 1'b0;
                        wait_next = wait_load;
                    end
                    else
                        poll_next = poll_reg + TW'(1);
                end
                i2cbm_pkg::PH_R_SCLL:
                begin
                    // Sample SDA into the low end while SCL is high.
                    shift_next   = rd_shift;
                    bit_cnt_next = bit_inc;
                    if (byte_end)
                        rd_hold_next = rd_shift;
                    scl_next  = 1'b0;
                    wait_next = wait_load;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg   <= i2cbm_pkg::DELAY_RESET;
            timeout_reg <= i2cbm_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                i2cbm_pkg::CFG_DELAY_TICKS: delay_reg   <= cfg_data[i2cbm_pkg::DELAY_W-1:0];
                i2cbm_pkg::CFG_ACK_TIMEOUT: timeout_reg <= cfg_data[TW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer state and result register, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cbm_pkg::PH_IDLE;
            wait_reg      <= '0;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            poll_reg      <= '0;
            nack_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            rd_hold_reg   <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                wait_reg    <= wait_next;
                bit_cnt_reg <= bit_cnt_next;
                shift_reg   <= shift_next;
                poll_reg    <= poll_next;
                nack_reg    <= nack_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                rd_hold_reg <= rd_hold_next;
                done_reg    <= done_next;
            end
            // Hold the result until taken; refill on every accepted item.
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // The result item is the state left by the last accepted tick.
    assign out_valid = out_valid_reg;
    assign scl_out   = scl_reg;
    assign sda_out   = sda_reg;
    assign busy_res  = (phase_reg != i2cbm_pkg::PH_IDLE);
    assign done_res  = done_reg;
    assign rd_byte   = rd_hold_reg;
    assign nack      = nack_reg;

endmodule
